// File: rtl/accel_tilt_pitch_roll_top_defines.svh
// Assertion macros shared by the tilt block's RTL.
`ifndef ACCEL_TILT_PITCH_ROLL_TOP_DEFINES_SVH
`define ACCEL_TILT_PITCH_ROLL_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define ATP_ASSERT_IMPL(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("atp assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ATP_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("atp assertion failed");

`endif

// File: rtl/atp_pkg.sv
// Types, constants and the arctangent table of the tilt block.
package atp_pkg;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int MAX_STAGES        = 24;

  localparam int AX_W   = 18;
  localparam int AYZ_W  = 17;
  localparam int SQ_W   = 34;
  localparam int N_W    = SQ_W + 16;
  localparam int ROOT_W = N_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CD_W   = 44;
  localparam int ANG_W  = 33;

  localparam logic signed [ANG_W-1:0] ONE_EIGHTY_FIX = 33'sd1179648000;
  localparam logic signed [ANG_W-1:0] HALF_LSB       = 33'sd32768;

  localparam logic [1:0] REG_X_OFFSET = 2'd0;
  localparam logic [1:0] REG_Y_OFFSET = 2'd1;
  localparam logic [1:0] REG_Z_OFFSET = 2'd2;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_t;

  typedef struct packed {
    logic signed [14:0] pitch_centideg;
    logic signed [15:0] roll_centideg;
  } out_t;

  typedef struct packed {
    logic signed [AX_W-1:0]  x;
    logic signed [AYZ_W-1:0] y;
    logic signed [AYZ_W-1:0] z;
  } side_t;

  typedef struct packed {
    logic              vld;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [N_W-1:0]    n;
    side_t             side;
  } sq_bus_t;

  typedef struct packed {
    logic                    vld;
    logic                    zero;
    logic signed [CD_W-1:0]  a;
    logic signed [CD_W-1:0]  b;
    logic signed [ANG_W-1:0] ang;
  } cd_bus_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 33'sd294912000;
      1:  v = 33'sd174096719;
      2:  v = 33'sd91987925;
      3:  v = 33'sd46694507;
      4:  v = 33'sd23437865;
      5:  v = 33'sd11730358;
      6:  v = 33'sd5866610;
      7:  v = 33'sd2933484;
      8:  v = 33'sd1466764;
      9:  v = 33'sd733385;
      10: v = 33'sd366693;
      11: v = 33'sd183346;
      12: v = 33'sd91673;
      13: v = 33'sd45837;
      14: v = 33'sd22918;
      15: v = 33'sd11459;
      16: v = 33'sd5730;
      17: v = 33'sd2865;
      18: v = 33'sd1432;
      19: v = 33'sd716;
      20: v = 33'sd358;
      21: v = 33'sd179;
      22: v = 33'sd90;
      23: v = 33'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/atp_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module atp_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  atp_pkg::sq_bus_t  d_in,
  output atp_pkg::sq_bus_t  d_out
);
  import atp_pkg::*;

  sq_bus_t          q_r;
  sq_bus_t          q_nxt;
  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;

  always_comb begin
    rem2  = {d_in.rem, d_in.n[N_W-1 -: 2]};
    trial = {2'b00, d_in.root, 2'b01};
    q_nxt      = d_in;
    q_nxt.n    = {d_in.n[N_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      q_nxt.rem  = REM_W'(rem2 - trial);
      q_nxt.root = {d_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      q_nxt.rem  = REM_W'(rem2);
      q_nxt.root = {d_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule

// File: rtl/atp_cordic_cell.sv
// One vectoring stage of the arctangent pipeline.
module atp_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  atp_pkg::cd_bus_t  d_in,
  output atp_pkg::cd_bus_t  d_out
);
  import atp_pkg::*;

  localparam logic signed [ANG_W-1:0] STEP_ANG = atan_entry(STAGE);

  cd_bus_t               q_r;
  cd_bus_t               q_nxt;
  logic signed [CD_W-1:0] da;
  logic signed [CD_W-1:0] db;

  always_comb begin
    da    = d_in.b >>> STAGE;
    db    = d_in.a >>> STAGE;
    q_nxt = d_in;
    if (!d_in.b[CD_W-1]) begin
      q_nxt.a   = d_in.a + da;
      q_nxt.b   = d_in.b - db;
      q_nxt.ang = d_in.ang + STEP_ANG;
    end else begin
      q_nxt.a   = d_in.a - da;
      q_nxt.b   = d_in.b + db;
      q_nxt.ang = d_in.ang - STEP_ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule

// File: rtl/accel_tilt_pitch_roll_top.sv
// Top level of the accelerometer pitch and roll block.
// Pipeline order: offset, square and sum registers, then the 25 square-root digit cells.
// One sample is taken every cycle; busy stays low, so throughput is one beat per clock.
// An operand register, the CORDIC stage cells and an output register follow and give the result.
// Synchronous reset clears all valid flags and the offset registers to zero.
`include "accel_tilt_pitch_roll_top_defines.svh"
module accel_tilt_pitch_roll_top #(
  parameter int CORDIC_STAGES = atp_pkg::DEF_CORDIC_STAGES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  atp_pkg::in_t in_data,
  output logic         out_valid,
  output atp_pkg::out_t out_data,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import atp_pkg::*;

  localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  logic signed [15:0] x_off_r, y_off_r, z_off_r;
  logic               cfg_wr;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= '0;
      y_off_r <= '0;
      z_off_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_X_OFFSET: x_off_r <= pwdata[15:0];
        REG_Y_OFFSET: y_off_r <= pwdata[15:0];
        REG_Z_OFFSET: z_off_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_X_OFFSET: prdata = {{16{x_off_r[15]}}, x_off_r};
      REG_Y_OFFSET: prdata = {{16{y_off_r[15]}}, y_off_r};
      REG_Z_OFFSET: prdata = {{16{z_off_r[15]}}, z_off_r};
      default:      prdata = '0;
    endcase
  end

  // Offset removal, with the x axis negated.
  logic  v0_r;
  side_t s0_r, s0_nxt;

  always_comb begin
    s0_nxt.x = -$signed({{2{in_data.accel_x[15]}}, in_data.accel_x})
               - $signed({{2{x_off_r[15]}}, x_off_r});
    s0_nxt.y = $signed({in_data.accel_y[15], in_data.accel_y})
               - $signed({y_off_r[15], y_off_r});
    s0_nxt.z = $signed({in_data.accel_z[15], in_data.accel_z})
               - $signed({z_off_r[15], z_off_r});
  end

  // Squares, then their sum.
  logic                  v1_r, v2_r;
  side_t                 s1_r, s2_r;
  logic [SQ_W-2:0]       xx_r, zz_r;
  logic [SQ_W-1:0]       sq_r;
  logic signed [2*AX_W-1:0]  xx_full;
  logic signed [2*AYZ_W-1:0] zz_full;

  assign xx_full = s0_r.x * s0_r.x;
  assign zz_full = s0_r.z * s0_r.z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s0_r;
    s2_r <= s1_r;
    xx_r <= xx_full[SQ_W-2:0];
    zz_r <= zz_full[SQ_W-2:0];
    sq_r <= {1'b0, xx_r} + {1'b0, zz_r};
  end

  // Square-root digit chain.
  sq_bus_t sq_bus [0:ROOT_W];

  always_comb begin
    sq_bus[0].vld  = v2_r;
    sq_bus[0].rem  = '0;
    sq_bus[0].root = '0;
    sq_bus[0].n    = {sq_r, 16'b0};
    sq_bus[0].side = s2_r;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    atp_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (sq_bus[k]),
      .d_out (sq_bus[k+1])
    );
  end

  // Operand setup for both arctangents.
  cd_bus_t pb [0:NSTG];
  cd_bus_t rb [0:NSTG];
  cd_bus_t pb_nxt, rb_nxt;
  side_t   sf;
  logic signed [CD_W-1:0] ra, rbv;

  always_comb begin
    sf = sq_bus[ROOT_W].side;

    pb_nxt.vld  = sq_bus[ROOT_W].vld;
    pb_nxt.a    = $signed({3'b000, sq_bus[ROOT_W].root, 16'b0});
    pb_nxt.b    = $signed({{3{sf.y[AYZ_W-1]}}, sf.y, 24'b0});
    pb_nxt.ang  = '0;
    pb_nxt.zero = (sq_bus[ROOT_W].root == '0) && (sf.y == '0);

    ra  = $signed({{3{sf.z[AYZ_W-1]}}, sf.z, 24'b0});
    rbv = $signed({{2{sf.x[AX_W-1]}}, sf.x, 24'b0});
    rb_nxt.vld  = sq_bus[ROOT_W].vld;
    rb_nxt.zero = (sf.z == '0) && (sf.x == '0);
    if (ra[CD_W-1]) begin
      rb_nxt.a   = -ra;
      rb_nxt.b   = -rbv;
      rb_nxt.ang = rbv[CD_W-1] ? -ONE_EIGHTY_FIX : ONE_EIGHTY_FIX;
    end else begin
      rb_nxt.a   = ra;
      rb_nxt.b   = rbv;
      rb_nxt.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb[0].vld <= 1'b0;
      rb[0].vld <= 1'b0;
    end else begin
      pb[0] <= pb_nxt;
      rb[0] <= rb_nxt;
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_cordic
    atp_cordic_cell #(.STAGE(s)) u_pitch (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (pb[s]),
      .d_out (pb[s+1])
    );
    atp_cordic_cell #(.STAGE(s)) u_roll (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (rb[s]),
      .d_out (rb[s+1])
    );
  end

  // Rounding and saturation; an angle is forced to zero when both of its operands are zero.
  logic signed [ANG_W-1:0]  p_sum, r_sum;
  logic signed [ANG_W-17:0] p_rnd, r_rnd;
  logic signed [14:0]       pitch_nxt;
  logic signed [15:0]       roll_nxt;
  logic                     out_valid_r;
  out_t                     out_data_r;

  always_comb begin
    p_sum = pb[NSTG].ang + HALF_LSB;
    r_sum = rb[NSTG].ang + HALF_LSB;
    p_rnd = p_sum[ANG_W-1:16];
    r_rnd = r_sum[ANG_W-1:16];

    if (pb[NSTG].zero) begin
      pitch_nxt = '0;
    end else if (p_rnd > 17'sd9000) begin
      pitch_nxt = 15'sd9000;
    end else if (p_rnd < -17'sd9000) begin
      pitch_nxt = -15'sd9000;
    end else begin
      pitch_nxt = p_rnd[14:0];
    end

    if (rb[NSTG].zero) begin
      roll_nxt = '0;
    end else if (r_rnd > 17'sd18000) begin
      roll_nxt = 16'sd18000;
    end else if (r_rnd < -17'sd18000) begin
      roll_nxt = -16'sd18000;
    end else begin
      roll_nxt = r_rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pb[NSTG].vld && rb[NSTG].vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.pitch_centideg <= pitch_nxt;
    out_data_r.roll_centideg  <= roll_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ATP_ASSERT_IMPL(a_chains_aligned, 1'b1, pb[NSTG].vld == rb[NSTG].vld)
  `ATP_ASSERT_IMPL(a_pitch_range, out_valid,
                   out_data.pitch_centideg <= 15'sd9000 && out_data.pitch_centideg >= -15'sd9000)
  `ATP_ASSERT_IMPL(a_roll_range, out_valid,
                   out_data.roll_centideg <= 16'sd18000 && out_data.roll_centideg >= -16'sd18000)
  `ATP_ASSERT_NEXT(a_strobe_follows, pb[NSTG].vld, out_valid)
endmodule
